// ===== src/sha_pkg.sv =====
// Shared types, constants and round tables for the SHA-256 message hasher.
// No dependencies; used by sha_core and sha256_message_hasher.
`default_nettype none

package sha_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BLK_WORDS  = 16;
    localparam int unsigned CH_WORDS   = 8;
    localparam int unsigned ROUNDS     = 64;
    localparam logic [7:0]  PAD_BYTE   = 8'h80;

    typedef logic [WORD_W-1:0] word_t;

    // Operation selected for the round datapath each cycle.
    typedef enum logic [1:0] {
        CORE_HOLD,
        CORE_LOAD,
        CORE_ROUND,
        CORE_SHIFT
    } core_op_t;

    typedef struct packed {
        core_op_t    op;
        logic [5:0]  round;
        word_t       data;
    } core_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD_FIRST,
        ST_PAD_ZERO,
        ST_PAD_LEN_HI,
        ST_PAD_LEN_LO,
        ST_LOADH,
        ST_ROUND,
        ST_ADDH,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

    // Where the sequencer goes once a compression has been folded back.
    typedef enum logic [1:0] {
        AFTER_IDLE,
        AFTER_PAD,
        AFTER_OUT
    } after_t;

    function automatic word_t sha_iv(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0:    r = 32'h6a09e667;
            3'd1:    r = 32'hbb67ae85;
            3'd2:    r = 32'h3c6ef372;
            3'd3:    r = 32'ha54ff53a;
            3'd4:    r = 32'h510e527f;
            3'd5:    r = 32'h9b05688c;
            3'd6:    r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t sha_k(input logic [5:0] idx);
        word_t r;
        case (idx)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;
            default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/sha_core.sv =====
// Round datapath: working variables a..h and the 16-word message schedule window.
// Depends on sha_pkg; sequenced by sha256_message_hasher.
`default_nettype none

module sha_core (
    input  wire logic              clk,
    input  wire sha_pkg::core_ctrl_t ctrl,
    output sha_pkg::word_t         v_first
);
    import sha_pkg::*;

    word_t v_reg [CH_WORDS];
    word_t w_reg [BLK_WORDS];
    word_t w_new;
    word_t t1;
    word_t t2;
    word_t big0;
    word_t big1;
    word_t choose;
    word_t major;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    always_comb
    begin
        // The first sixteen schedule words come straight from the block memory.
        if (ctrl.round < 6'd16)
        begin
            w_new = ctrl.data;
        end
        else
        begin
            w_new = (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10))
                  + w_reg[9]
                  + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
                  + w_reg[0];
        end
        big1   = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        choose = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        big0   = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        major  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1     = v_reg[7] + big1 + choose + sha_k(ctrl.round) + w_new;
        t2     = big0 + major;
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            CORE_LOAD:
            begin
                // Chaining words arrive in index order and shift toward a.
                for (int i = 0; i < CH_WORDS - 1; i++)
                begin
                    v_reg[i] <= v_reg[i+1];
                end
                v_reg[CH_WORDS-1] <= ctrl.data;
            end
            CORE_SHIFT:
            begin
                for (int i = 0; i < CH_WORDS - 1; i++)
                begin
                    v_reg[i] <= v_reg[i+1];
                end
                v_reg[CH_WORDS-1] <= v_reg[0];
            end
            CORE_ROUND:
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                for (int i = 0; i < BLK_WORDS - 1; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[BLK_WORDS-1] <= w_new;
            end
            default:
            begin
            end
        endcase
    end

    assign v_first = v_reg[0];

endmodule

`default_nettype wire

// ===== src/sha256_message_hasher.sv =====
// Channel  Fields (tdata / tuser / tlast)                    Direction
// s_       tdata: data_byte[7:0]; tuser: kind                 in
// m_       tdata: digest_word[31:0], word_index[34:32]; tlast  out
//
// Every 64th appended byte runs one compression on the single round unit: a read
// of the chaining memory, 64 rounds at one per cycle, and a fold-back. A finish
// transaction writes up to 18 padding words, runs one or two compressions and gives
// each digest word after a chaining memory read. Reset is asynchronous; the chaining
// memory reads as the initial hash values until the first block is folded back.
// Input is taken only while idle; a stalled output word holds the sequencer.
// Depends on sha_pkg and sha_core.
`default_nettype none

module sha256_message_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // digest_word[31:0], word_index[34:32], zeros
    output logic             m_tlast
);
    import sha_pkg::*;

    state_t      state_reg, state_next;
    after_t      after_reg, after_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  bib_reg, bib_next;
    logic [63:0] len_reg, len_next;
    logic [23:0] acc_reg, acc_next;
    logic [4:0]  pad_word_reg, pad_word_next;
    logic        pad_wrap_reg, pad_wrap_next;
    logic        fresh_reg, fresh_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        m_valid_reg, m_valid_next;
    word_t       m_word_reg, m_word_next;
    logic [2:0]  m_index_reg, m_index_next;
    logic        m_last_reg, m_last_next;

    // Block buffer memory: sixteen big-endian message words.
    word_t       blk_mem [BLK_WORDS];
    logic        blk_we;
    logic [3:0]  blk_waddr;
    word_t       blk_wdata;
    logic        blk_re;
    logic [3:0]  blk_raddr;
    word_t       blk_q_reg;

    // Chaining word memory.
    word_t       ch_mem [CH_WORDS];
    logic        ch_we;
    logic [2:0]  ch_waddr;
    word_t       ch_wdata;
    logic        ch_re;
    logic [2:0]  ch_raddr;
    word_t       ch_q_reg;
    logic [2:0]  ch_raddr_reg;
    word_t       ch_rdata;

    core_ctrl_t  core_ctrl;
    word_t       v_first;
    word_t       pad_first_word;
    logic        s_fire;

    sha_core u_core (
        .clk     (clk),
        .ctrl    (core_ctrl),
        .v_first (v_first)
    );

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        if (blk_re)
        begin
            blk_q_reg <= blk_mem[blk_raddr];
        end
        if (ch_we)
        begin
            ch_mem[ch_waddr] <= ch_wdata;
        end
        if (ch_re)
        begin
            ch_q_reg     <= ch_mem[ch_raddr];
            ch_raddr_reg <= ch_raddr;
        end
    end

    // Until the first fold-back of a message, the chaining memory stands for the
    // initial hash values; this replaces a clearing pass.
    assign ch_rdata = fresh_reg ? sha_iv(ch_raddr_reg) : ch_q_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_index_reg, m_word_reg};
    assign m_tlast  = m_last_reg;

    // Final partial word: bytes held so far, the marker byte, then zeros.
    always_comb
    begin
        case (bib_reg[1:0])
            2'd0:    pad_first_word = {PAD_BYTE, 24'd0};
            2'd1:    pad_first_word = {acc_reg[7:0], PAD_BYTE, 16'd0};
            2'd2:    pad_first_word = {acc_reg[15:0], PAD_BYTE, 8'd0};
            default: pad_first_word = {acc_reg[23:0], PAD_BYTE};
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        after_next     = after_reg;
        cnt_next       = cnt_reg;
        bib_next       = bib_reg;
        len_next       = len_reg;
        acc_next       = acc_reg;
        pad_word_next  = pad_word_reg;
        pad_wrap_next  = pad_wrap_reg;
        fresh_next     = fresh_reg;
        out_idx_next   = out_idx_reg;
        m_valid_next   = m_valid_reg;
        m_word_next    = m_word_reg;
        m_index_next   = m_index_reg;
        m_last_next    = m_last_reg;
        blk_we         = 1'b0;
        blk_waddr      = bib_reg[5:2];
        blk_wdata      = '0;
        blk_re         = 1'b0;
        blk_raddr      = '0;
        ch_we          = 1'b0;
        ch_waddr       = '0;
        ch_wdata       = ch_rdata + v_first;
        ch_re          = 1'b0;
        ch_raddr       = cnt_reg[2:0];
        core_ctrl.op    = CORE_HOLD;
        core_ctrl.round = cnt_reg;
        core_ctrl.data  = blk_q_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (!s_tuser)
                    begin
                        acc_next = {acc_reg[15:0], s_tdata};
                        if (bib_reg[1:0] == 2'd3)
                        begin
                            blk_we    = 1'b1;
                            blk_wdata = {acc_reg, s_tdata};
                        end
                        bib_next = bib_reg + 6'd1;
                        len_next = len_reg + 64'd8;
                        if (bib_reg == 6'd63)
                        begin
                            state_next = ST_LOADH;
                            cnt_next   = '0;
                            after_next = AFTER_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = ST_PAD_FIRST;
                    end
                end
            end
            ST_PAD_FIRST:
            begin
                blk_we        = 1'b1;
                blk_wdata     = pad_first_word;
                pad_word_next = {1'b0, bib_reg[5:2]} + 5'd1;
                // No room for the length after the marker: pad out an extra block.
                pad_wrap_next = (bib_reg[5:3] == 3'd7);
                state_next    = ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                if (pad_wrap_reg ? (pad_word_reg < 5'd16) : (pad_word_reg < 5'd14))
                begin
                    blk_we        = 1'b1;
                    blk_waddr     = pad_word_reg[3:0];
                    pad_word_next = pad_word_reg + 5'd1;
                end
                else if (pad_wrap_reg)
                begin
                    state_next = ST_LOADH;
                    cnt_next   = '0;
                    after_next = AFTER_PAD;
                end
                else
                begin
                    state_next = ST_PAD_LEN_HI;
                end
            end
            ST_PAD_LEN_HI:
            begin
                blk_we     = 1'b1;
                blk_waddr  = 4'd14;
                blk_wdata  = len_reg[63:32];
                state_next = ST_PAD_LEN_LO;
            end
            ST_PAD_LEN_LO:
            begin
                blk_we     = 1'b1;
                blk_waddr  = 4'd15;
                blk_wdata  = len_reg[31:0];
                state_next = ST_LOADH;
                cnt_next   = '0;
                after_next = AFTER_OUT;
            end
            ST_LOADH:
            begin
                ch_re = (cnt_reg < 6'd8);
                if (cnt_reg != 6'd0)
                begin
                    core_ctrl.op   = CORE_LOAD;
                    core_ctrl.data = ch_rdata;
                end
                if (cnt_reg == 6'd8)
                begin
                    // Prefetch the first schedule word for round zero.
                    blk_re     = 1'b1;
                    blk_raddr  = '0;
                    state_next = ST_ROUND;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_ROUND:
            begin
                core_ctrl.op = CORE_ROUND;
                if (cnt_reg < 6'd15)
                begin
                    blk_re    = 1'b1;
                    blk_raddr = cnt_reg[3:0] + 4'd1;
                end
                if (cnt_reg == 6'd63)
                begin
                    state_next = ST_ADDH;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_ADDH:
            begin
                ch_re = (cnt_reg < 6'd8);
                if (cnt_reg != 6'd0)
                begin
                    // Entry cnt-1 is written while entry cnt is read, never the same one.
                    ch_we        = 1'b1;
                    ch_waddr     = cnt_reg[2:0] - 3'd1;
                    core_ctrl.op = CORE_SHIFT;
                end
                if (cnt_reg == 6'd8)
                begin
                    fresh_next = 1'b0;
                    case (after_reg)
                        AFTER_PAD:
                        begin
                            state_next    = ST_PAD_ZERO;
                            pad_word_next = '0;
                            pad_wrap_next = 1'b0;
                        end
                        AFTER_OUT:
                        begin
                            state_next   = ST_OUT_RD;
                            out_idx_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_OUT_RD:
            begin
                ch_re      = 1'b1;
                ch_raddr   = out_idx_reg;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_word_next  = ch_rdata;
                    m_index_next = out_idx_reg;
                    m_last_next  = (out_idx_reg == 3'd7);
                    if (out_idx_reg == 3'd7)
                    begin
                        // Message done: back to the initial state for the next one.
                        state_next = ST_IDLE;
                        fresh_next = 1'b1;
                        bib_next   = '0;
                        len_next   = '0;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            after_reg    <= AFTER_IDLE;
            cnt_reg      <= '0;
            bib_reg      <= '0;
            len_reg      <= '0;
            pad_word_reg <= '0;
            pad_wrap_reg <= 1'b0;
            fresh_reg    <= 1'b1;
            out_idx_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            after_reg    <= after_next;
            cnt_reg      <= cnt_next;
            bib_reg      <= bib_next;
            len_reg      <= len_next;
            pad_word_reg <= pad_word_next;
            pad_wrap_reg <= pad_wrap_next;
            fresh_reg    <= fresh_next;
            out_idx_reg  <= out_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        m_word_reg  <= m_word_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
    end

    // The block buffer is never overwritten while its words feed the rounds.
    assert property (@(posedge clk) disable iff (!rst_n)
        blk_we |-> (state_reg != ST_ROUND && state_reg != ST_LOADH))
        else $error("block buffer written during compression");

    // The 64th byte of a block starts a compression at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !s_tuser && bib_reg == 6'd63) |=> (state_reg == ST_LOADH))
        else $error("full block did not start compression");

    // Only the eighth digest word carries the last mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[34:32] == 3'd7))
        else $error("last mark on a word other than the eighth");

    // The initial-value overlay ends only when a fold-back completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(fresh_reg) |-> ($past(state_reg) == ST_ADDH))
        else $error("chaining overlay dropped outside fold-back");

endmodule

`default_nettype wire

// ===== tb/tb_sha256_message_hasher.sv =====
// Self-checking testbench for sha256_message_hasher: byte messages go in on the s_ stream,
// and digest words on the m_ stream are checked against a SHA-256 model kept in the bench.
// Depends on sha_pkg and the RTL of sha256_message_hasher.
`default_nettype none

module tb_sha256_message_hasher;

    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::*;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int unsigned ITEM_TARGET  = 330;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned END_SETTLE   = 300;
    localparam int unsigned DIRECTED_LEN = 16;

    localparam word_t ROUND_CONST [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t START_HASH [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    typedef struct packed {
        word_t      word;
        logic [2:0] index;
        logic       last;
    } digest_word_t;

    typedef struct packed {
        logic         kind;
        logic [7:0]   data;
        logic         known;
        logic [255:0] digest;
    } stim_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = KIND_APPEND;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    sha256_message_hasher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Hash state of the bench model.
    word_t        chain_words [0:7];
    logic [7:0]   msg_block   [0:63];
    int unsigned  block_fill;
    logic [63:0]  msg_bits;

    digest_word_t digest_words_due [$];
    int unsigned  mismatch_count = 0;
    int unsigned  items_sent     = 0;
    int unsigned  quiet_cycles   = 0;
    int unsigned  burst_left     = 0;
    stim_row_t    directed_rows [0:DIRECTED_LEN-1];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++)
            chain_words[i] = START_HASH[i];
        block_fill = 0;
        msg_bits   = '0;
    endfunction

    function automatic void fold_block();
        word_t sched [0:63];
        word_t v     [0:7];
        word_t t1;
        word_t t2;
        for (int i = 0; i < 16; i++)
            sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            sched[i] = sched[i-16] + sched[i-7]
                     + (rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3))
                     + (rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = chain_words[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + sched[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_words[i] = chain_words[i] + v[i];
    endfunction

    // Takes one accepted transaction; returns 1 with the digest when the message is finished.
    function automatic bit hash_absorb(input logic kind, input logic [7:0] data,
                                       output logic [255:0] digest);
        int unsigned pos;
        digest = '0;
        if (kind == KIND_APPEND)
        begin
            msg_block[block_fill] = data;
            msg_bits = msg_bits + 64'd8;
            block_fill++;
            if (block_fill == 64)
            begin
                fold_block();
                block_fill = 0;
            end
            return 1'b0;
        end
        pos = block_fill;
        msg_block[pos] = PAD_BYTE;
        pos++;
        // The length field no longer fits, so the padding spills into one more block.
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            fold_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = msg_bits[63-8*i -: 8];
        fold_block();
        for (int i = 0; i < 8; i++)
            digest[255-32*i -: 32] = chain_words[i];
        hash_restart();
        return 1'b1;
    endfunction

    task automatic send_item(input logic kind, input logic [7:0] data,
                             input logic known, input logic [255:0] known_digest);
        logic [255:0] predicted;
        logic [255:0] due;
        digest_word_t w;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (hash_absorb(kind, data, predicted))
        begin
            due = known ? known_digest : predicted;
            for (int i = 0; i < 8; i++)
            begin
                w.word  = due[255-32*i -: 32];
                w.index = 3'(i);
                w.last  = (i == 7);
                digest_words_due.push_back(w);
            end
        end
    endtask

    task automatic sender_idle(input int unsigned cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_digests();
        s_tvalid <= 1'b0;
        while (digest_words_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic paced_send(input logic kind, input logic [7:0] data);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // A long stretch with no gaps at all.
                burst_left = 64;
            end
            else
            begin
                sender_idle($urandom_range(1, 6));
                burst_left = $urandom_range(1, 20);
            end
        end
        burst_left--;
        send_item(kind, data, 1'b0, '0);
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            paced_send(KIND_APPEND, 8'($urandom));
        paced_send(KIND_FINISH, 8'($urandom));
    endtask

    function automatic int unsigned pick_length();
        int unsigned len;
        case ($urandom_range(0, 11))
            0:       len = 0;
            1:       len = 55;
            2:       len = 56;
            3:       len = 57;
            4:       len = 63;
            5:       len = 64;
            6:       len = 65;
            7:       len = $urandom_range(119, 128);
            default: len = $urandom_range(1, 40);
        endcase
        return len;
    endfunction

    // Receiver: runs of ready and stall of random length, with some long ready stretches.
    int unsigned ready_run = 0;
    always @(posedge clk)
    begin
        if (ready_run == 0)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    m_tready  <= 1'b1;
                    ready_run <= 40;
                end
                1, 2:
                begin
                    m_tready  <= 1'b0;
                    ready_run <= $urandom_range(1, 8);
                end
                default:
                begin
                    m_tready  <= 1'b1;
                    ready_run <= $urandom_range(1, 12);
                end
            endcase
        end
        else
        begin
            ready_run <= ready_run - 1;
        end
    end

    always @(posedge clk)
    begin
        digest_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_words_due.size() == 0)
            begin
                $error("digest word with no expectation: digest_word=%h word_index=%0d",
                       m_tdata[31:0], m_tdata[34:32]);
                mismatch_count++;
            end
            else
            begin
                want = digest_words_due.pop_front();
                if (m_tdata[31:0] !== want.word)
                begin
                    $error("digest_word: expected %h, actual %h", want.word, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[34:32] !== want.index)
                begin
                    $error("word_index: expected %0d, actual %0d", want.index, m_tdata[34:32]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_word: expected %0b, actual %0b", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb_sha256_message_hasher failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned msg_len;
        directed_rows = '{
            '{KIND_FINISH, 8'h5a, 1'b1, EMPTY_DIGEST},
            '{KIND_APPEND, 8'h61, 1'b0, 256'h0},
            '{KIND_APPEND, 8'h62, 1'b0, 256'h0},
            '{KIND_APPEND, 8'h63, 1'b0, 256'h0},
            '{KIND_FINISH, 8'h00, 1'b1, ABC_DIGEST},
            '{KIND_APPEND, 8'h00, 1'b0, 256'h0},
            '{KIND_APPEND, 8'hff, 1'b0, 256'h0},
            '{KIND_APPEND, 8'h80, 1'b0, 256'h0},
            '{KIND_APPEND, 8'h7f, 1'b0, 256'h0},
            '{KIND_FINISH, 8'hff, 1'b0, 256'h0},
            // A finish right after a finish hashes the empty message again.
            '{KIND_FINISH, 8'ha5, 1'b1, EMPTY_DIGEST},
            '{KIND_APPEND, 8'haa, 1'b0, 256'h0},
            '{KIND_APPEND, 8'h55, 1'b0, 256'h0},
            '{KIND_APPEND, 8'h01, 1'b0, 256'h0},
            '{KIND_APPEND, 8'hfe, 1'b0, 256'h0},
            '{KIND_FINISH, 8'h3c, 1'b0, 256'h0}
        };
        hash_restart();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
            send_item(directed_rows[i].kind, directed_rows[i].data,
                      directed_rows[i].known, directed_rows[i].digest);
        drain_digests();

        for (int msg = 0; items_sent < ITEM_TARGET; msg++)
        begin
            msg_len = pick_length();
            // The last message is shortened so the run stays close to the item target.
            if (msg_len > ITEM_TARGET - items_sent)
                msg_len = ITEM_TARGET - items_sent;
            send_message(msg_len);
            if (msg == 4)
                drain_digests();
        end

        drain_digests();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && digest_words_due.size() == 0)
            $display("tb_sha256_message_hasher passed");
        else
            $display("tb_sha256_message_hasher failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/sha_pkg.sv
src/sha_core.sv
src/sha256_message_hasher.sv
tb/tb_sha256_message_hasher.sv
